FILE: rtl/xtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and the round mixing function of the XTEA core.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_IDX_W = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] XT_DELTA = 32'h9e37_79b9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd3;

    // Operation codes
    localparam logic FUNC_ENCIPHER = 1'b0;
    localparam logic FUNC_DECIPHER = 1'b1;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] block_lo;
        logic [WORD_W-1:0] block_hi;
    } xtea_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_lo;
        logic [WORD_W-1:0] out_hi;
    } xtea_out_t;

    // ((v << 4) ^ (v >> 5)) + v, modulo 2^32
    function automatic logic [WORD_W-1:0] xt_mix(input logic [WORD_W-1:0] v);
        xt_mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

FILE: rtl/xtea_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_cipher
// Pipelined XTEA cipher, one half-round per register stage, key in four
// configuration words.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_ready    | in_data  : func, block_lo, block_hi
//  output   | out_valid / out_ready  | out_data : out_lo, out_hi
//  config   | cfg_we (no wait)       | cfg_index, cfg_data (key words 0..3)
//
//  One item per cycle sustained while out_ready stays high; one stage per
//  half-round, the last stage being the output register.
//  Reset clears the valid bits of every stage and the key words to zero.
//  Each stage has its own ready: a stage loads whenever it is empty or its
//  successor moves, so bubbles close up and a held result does not stop
//  items entering until the whole pipe is full.
//
module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  xtea_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output xtea_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    // Two half-rounds per round, one stage each
    localparam int unsigned NS = 2 * ROUNDS;

    // ------------------------------------------------------------------
    // Key words
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] key_reg [KEY_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            // Writes beyond the last key word are dropped
            unique case (cfg_index)
                REG_KEY_WORD0: key_reg[0] <= cfg_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline stages
    // ------------------------------------------------------------------
    logic [NS-1:0]     valid_reg;
    logic [NS-1:0]     func_reg;
    logic [WORD_W-1:0] v0_reg [NS];
    logic [WORD_W-1:0] v1_reg [NS];

    // rdy[s]: stage s may load this cycle; rdy[NS] is the downstream ready
    logic [NS:0] rdy;

    assign rdy[NS] = out_ready;

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            localparam int unsigned RND = s / 2;
            // Running sums for this half-round, fixed per stage and direction
            localparam logic [63:0] ENC_PROD =
                64'(XT_DELTA) * 64'((s % 2 == 0) ? RND : RND + 1);
            localparam logic [63:0] DEC_PROD =
                64'(XT_DELTA) * 64'((s % 2 == 0) ? ROUNDS - RND : ROUNDS - RND - 1);
            localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
            localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];
            // Half A keys on sum[1:0] when enciphering, sum[12:11] when
            // deciphering; half B the other way round
            localparam logic [KEY_IDX_W-1:0] ENC_KIDX = (s % 2 == 0) ?
                ENC_SUM[1:0] : ENC_SUM[12:11];
            localparam logic [KEY_IDX_W-1:0] DEC_KIDX = (s % 2 == 0) ?
                DEC_SUM[12:11] : DEC_SUM[1:0];

            logic              pv_valid;
            logic              p_func;
            logic [WORD_W-1:0] p_v0;
            logic [WORD_W-1:0] p_v1;
            logic [WORD_W-1:0] src;
            logic [WORD_W-1:0] sum_sel;
            logic [WORD_W-1:0] key_sel;
            logic [WORD_W-1:0] term;
            logic [WORD_W-1:0] v0_next;
            logic [WORD_W-1:0] v1_next;
            logic              dec;

            if (s == 0)
            begin : g_first
                assign pv_valid = in_valid;
                assign p_func   = in_data.func;
                assign p_v0     = in_data.block_lo;
                assign p_v1     = in_data.block_hi;
            end
            else
            begin : g_next
                assign pv_valid = valid_reg[s-1];
                assign p_func   = func_reg[s-1];
                assign p_v0     = v0_reg[s-1];
                assign p_v1     = v1_reg[s-1];
            end

            assign dec     = (p_func == FUNC_DECIPHER);
            assign sum_sel = dec ? DEC_SUM : ENC_SUM;
            assign key_sel = dec ? key_reg[DEC_KIDX] : key_reg[ENC_KIDX];

            if (s % 2 == 0)
            begin : g_half_a
                // encipher: v0 += F(v1); decipher: v1 -= F(v0)
                assign src     = dec ? p_v0 : p_v1;
                assign term    = xt_mix(src) ^ (sum_sel + key_sel);
                assign v0_next = dec ? p_v0 : p_v0 + term;
                assign v1_next = dec ? p_v1 - term : p_v1;
            end
            else
            begin : g_half_b
                // encipher: v1 += F(v0); decipher: v0 -= F(v1)
                assign src     = dec ? p_v1 : p_v0;
                assign term    = xt_mix(src) ^ (sum_sel + key_sel);
                assign v0_next = dec ? p_v0 - term : p_v0;
                assign v1_next = dec ? p_v1 : p_v1 + term;
            end

            // Load when empty or when the successor takes the current item
            assign rdy[s] = !valid_reg[s] || rdy[s+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (rdy[s])
                begin
                    valid_reg[s] <= pv_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && pv_valid)
                begin
                    func_reg[s] <= p_func;
                    v0_reg[s]   <= v0_next;
                    v1_reg[s]   <= v1_next;
                end
            end
        end
    endgenerate

    assign in_ready        = rdy[0];
    assign out_valid       = valid_reg[NS-1];
    assign out_data.out_lo = v0_reg[NS-1];
    assign out_data.out_hi = v1_reg[NS-1];

`ifndef NO_ASSERTIONS
    // An empty output stage means every stage can load
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("in_ready low while output stage is empty");

    // An accepted item lands in the first stage
    a_first_stage_loads: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0]
    ) else $error("accepted item missing from first stage");

    // Items are neither lost nor duplicated inside the pipe
    a_occupancy_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && !(out_valid && out_ready))
            |=> ($countones(valid_reg) == $past($countones(valid_reg)))
    ) else $error("pipeline occupancy changed without a handshake");
`endif

endmodule
